>>> hdl/swdc_pkg.sv
package swdc_pkg;

    localparam int MAX_WINDOW_DEF  = 64;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int CFG_W           = 7;
    localparam int OUT_W           = 7;
    localparam int WINDOW_RESET    = 16;

    // per-cell match flags against the incoming and the leaving value
    typedef struct packed {
        logic new_hit;
        logic old_hit;
    } cell_hit_t;

endpackage

>>> hdl/swdc_cell.sv
module swdc_cell #(
    parameter int INDEX       = 0,
    parameter int VALUE_WIDTH = swdc_pkg::VALUE_WIDTH_DEF,
    parameter int CNT_W       = 7
) (
    input  logic                   aclk,
    input  logic                   shift_en,
    input  logic [VALUE_WIDTH-1:0] prev_value,
    input  logic [VALUE_WIDTH-1:0] new_value,
    input  logic [VALUE_WIDTH-1:0] old_value,
    input  logic [CNT_W-1:0]       active_limit,
    output logic [VALUE_WIDTH-1:0] cell_value,
    output swdc_pkg::cell_hit_t    hit
);
    import swdc_pkg::*;

    logic [VALUE_WIDTH-1:0] value_reg;
    logic                   active;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            value_reg <= prev_value;
        end
    end

    // a cell only takes part once it holds a value of the remaining window
    assign active      = CNT_W'(INDEX) < active_limit;
    assign hit.new_hit = active && (value_reg == new_value);
    assign hit.old_hit = active && (value_reg == old_value);
    assign cell_value  = value_reg;

endmodule

>>> hdl/sliding_window_distinct_count_top.sv
// channel   | ports                          | beat
// ----------+--------------------------------+---------------------------------
// input     | s_valid s_ready s_sample_value | one stream value
// result    | m_valid m_ready m_distinct_count | distinct values in full window
// config    | cfg_valid cfg_ready cfg_data   | window size, restarts the stream
//
// one beat per cycle: the cell row compares the incoming and the leaving value
// against all held values in parallel, and the count updates in the same cycle.
// the result sits in an output register; a new beat is taken when it is empty
// or being taken in the same cycle. a config write restarts the window at once,
// and the input is held off while a config write is offered.
// synchronous active-low reset; the window refills before the first result.
module sliding_window_distinct_count_top #(
    parameter int MAX_WINDOW  = swdc_pkg::MAX_WINDOW_DEF,
    parameter int VALUE_WIDTH = swdc_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [VALUE_WIDTH-1:0]        s_sample_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [swdc_pkg::OUT_W-1:0]    m_distinct_count,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [swdc_pkg::CFG_W-1:0]    cfg_data
);
    import swdc_pkg::*;

    localparam int CNT_W   = $clog2(MAX_WINDOW + 1);
    localparam int NCELL   = (MAX_WINDOW > 1) ? MAX_WINDOW - 1 : 1;
    localparam int IDX_W   = (NCELL > 1) ? $clog2(NCELL) : 1;
    localparam int EXT_W   = CNT_W + CFG_W;
    localparam int WS_INIT = (WINDOW_RESET > MAX_WINDOW) ? MAX_WINDOW : WINDOW_RESET;

    logic [CNT_W-1:0]       ws_reg, ws_next;
    logic [CNT_W-1:0]       fill_reg, fill_next;
    logic [CNT_W-1:0]       distinct_reg, distinct_next;
    logic [VALUE_WIDTH-1:0] old_reg;
    logic                   m_valid_reg;
    logic [OUT_W-1:0]       m_count_reg, m_count_next;

    logic                   s_fire, cfg_fire, removal, new_in, old_gone, emit;
    logic [CNT_W-1:0]       active_limit, sel;
    logic [EXT_W-1:0]       cfg_ext;
    logic [CNT_W+OUT_W-1:0] count_wide;
    logic [VALUE_WIDTH-1:0] cell_val [NCELL];
    cell_hit_t              hits [NCELL];
    logic [NCELL-1:0]       new_hits, old_hits;

    assign cfg_ready = 1'b1;
    assign s_ready   = (!m_valid_reg || m_ready) && !cfg_valid;
    assign s_fire    = s_valid && s_ready;
    assign cfg_fire  = cfg_valid && cfg_ready;

    // when the window is full the oldest cell leaves, so it is left out
    assign removal      = (fill_reg == ws_reg);
    assign active_limit = fill_reg - CNT_W'(removal);

    genvar i;
    generate
        for (i = 0; i < NCELL; i++) begin : g_cell
            logic [VALUE_WIDTH-1:0] prev_value;
            if (i == 0) begin : g_head
                assign prev_value = s_sample_value;
            end else begin : g_link
                assign prev_value = cell_val[i-1];
            end
            swdc_cell #(
                .INDEX       (i),
                .VALUE_WIDTH (VALUE_WIDTH),
                .CNT_W       (CNT_W)
            ) u_cell (
                .aclk         (aclk),
                .shift_en     (s_fire),
                .prev_value   (prev_value),
                .new_value    (s_sample_value),
                .old_value    (old_reg),
                .active_limit (active_limit),
                .cell_value   (cell_val[i]),
                .hit          (hits[i])
            );
            assign new_hits[i] = hits[i].new_hit;
            assign old_hits[i] = hits[i].old_hit;
        end
    endgenerate

    assign new_in   = ~|new_hits;
    assign old_gone = removal && ~|old_hits;

    always_comb begin
        distinct_next = distinct_reg + CNT_W'(new_in) - CNT_W'(old_gone);
        fill_next     = (fill_reg < ws_reg) ? fill_reg + CNT_W'(1) : fill_reg;
        emit          = (fill_next == ws_reg);
        count_wide    = {{OUT_W{1'b0}}, distinct_next};
        m_count_next  = count_wide[OUT_W-1:0];
        sel           = ws_reg - CNT_W'(2);
        cfg_ext       = {{CNT_W{1'b0}}, cfg_data};
        if (cfg_ext == '0) begin
            ws_next = CNT_W'(1);
        end else if (cfg_ext > EXT_W'(MAX_WINDOW)) begin
            ws_next = CNT_W'(MAX_WINDOW);
        end else begin
            ws_next = cfg_ext[CNT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ws_reg       <= CNT_W'(WS_INIT);
            fill_reg     <= '0;
            distinct_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_fire) begin
                ws_reg       <= ws_next;
                fill_reg     <= '0;
                distinct_reg <= '0;
            end else if (s_fire) begin
                fill_reg     <= fill_next;
                distinct_reg <= distinct_next;
            end
            if (s_fire && emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // leaving value of the next window: the cell one short of the window end
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            m_count_reg <= m_count_next;
            old_reg     <= (ws_reg == CNT_W'(1)) ? s_sample_value : cell_val[sel[IDX_W-1:0]];
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_distinct_count = m_count_reg;

    a_distinct_le_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        distinct_reg <= fill_reg)
        else $error("distinct count exceeds fill level");

    a_fill_le_window: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= ws_reg)
        else $error("fill level exceeds window size");

    a_nonempty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (fill_reg != '0) |-> (distinct_reg != '0))
        else $error("nonempty window with zero distinct values");

    a_fill_after_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && !cfg_fire) |=> (fill_reg != '0))
        else $error("accepted beat left the window empty");

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int VW            = swdc_pkg::VALUE_WIDTH_DEF;
    localparam int CW            = swdc_pkg::CFG_W;
    localparam int OW            = swdc_pkg::OUT_W;
    localparam int RANDOM_ITEMS  = 400;
    localparam int CALM_TAIL     = 60;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 4;
    localparam int QUIET_LIMIT   = 2000;
    localparam int N_DIRECTED    = 30;

    typedef enum logic {ROW_SAMPLE, ROW_WINDOW} row_kind_t;

    typedef struct packed {
        row_kind_t       kind;
        logic [VW-1:0]   value;
        logic            typed;
        logic [OW-1:0]   count;
    } stim_row_t;

    logic          aclk           = 1'b0;
    logic          aresetn        = 1'b0;
    logic          s_valid        = 1'b0;
    logic          s_ready;
    logic [VW-1:0] s_sample_value = '0;
    logic          m_valid;
    logic          m_ready        = 1'b0;
    logic [OW-1:0] m_distinct_count;
    logic          cfg_valid      = 1'b0;
    logic          cfg_ready;
    logic [CW-1:0] cfg_data       = '0;

    // window tracker: live window contents and occurrence count per value
    logic [CW-1:0] window_reg = CW'(swdc_pkg::WINDOW_RESET);
    logic [VW-1:0] window_vals [$];
    int unsigned   occurrences [logic [VW-1:0]];
    logic [OW-1:0] expected_counts [$];

    int  fail_count   = 0;
    int  quiet_cycles = 0;
    bit  idle_on      = 1'b1;
    bit  hold_request = 1'b0;

    stim_row_t directed_rows [N_DIRECTED] = '{
        '{ROW_SAMPLE, 32'h0000_0000, 1'b0, 7'd0},
        '{ROW_SAMPLE, 32'hFFFF_FFFF, 1'b0, 7'd0},
        '{ROW_WINDOW, 32'd1,         1'b0, 7'd0},
        '{ROW_SAMPLE, 32'h0000_0000, 1'b1, 7'd1},
        '{ROW_SAMPLE, 32'hFFFF_FFFF, 1'b1, 7'd1},
        '{ROW_WINDOW, 32'd0,         1'b0, 7'd0},
        '{ROW_SAMPLE, 32'h8000_0000, 1'b1, 7'd1},
        '{ROW_WINDOW, 32'd2,         1'b0, 7'd0},
        '{ROW_SAMPLE, 32'h0000_0007, 1'b0, 7'd0},
        '{ROW_SAMPLE, 32'h0000_0007, 1'b1, 7'd1},
        '{ROW_SAMPLE, 32'h8000_0007, 1'b1, 7'd2},
        '{ROW_WINDOW, 32'd3,         1'b0, 7'd0},
        '{ROW_SAMPLE, 32'h0000_0001, 1'b0, 7'd0},
        '{ROW_SAMPLE, 32'h0000_0002, 1'b0, 7'd0},
        '{ROW_SAMPLE, 32'h0000_0003, 1'b1, 7'd3},
        '{ROW_SAMPLE, 32'h0000_0001, 1'b1, 7'd3},
        '{ROW_SAMPLE, 32'h0000_0001, 1'b1, 7'd2},
        '{ROW_SAMPLE, 32'h0000_0001, 1'b1, 7'd1},
        '{ROW_WINDOW, 32'd3,         1'b0, 7'd0},
        '{ROW_SAMPLE, 32'h0000_0001, 1'b0, 7'd0},
        '{ROW_SAMPLE, 32'h0000_0005, 1'b0, 7'd0},
        '{ROW_WINDOW, 32'd127,       1'b0, 7'd0},
        '{ROW_SAMPLE, 32'h5555_AAAA, 1'b0, 7'd0},
        '{ROW_WINDOW, 32'd65,        1'b0, 7'd0},
        '{ROW_SAMPLE, 32'hAAAA_5555, 1'b0, 7'd0},
        '{ROW_WINDOW, 32'd4,         1'b0, 7'd0},
        '{ROW_SAMPLE, 32'hFFFF_FFFF, 1'b0, 7'd0},
        '{ROW_SAMPLE, 32'hFFFF_FFFF, 1'b0, 7'd0},
        '{ROW_SAMPLE, 32'hFFFF_FFFF, 1'b0, 7'd0},
        '{ROW_SAMPLE, 32'hFFFF_FFFF, 1'b1, 7'd1}
    };

    sliding_window_distinct_count_top dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_sample_value   (s_sample_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_distinct_count (m_distinct_count),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic int unsigned span_of(input logic [CW-1:0] w);
        if (w == '0) return 1;
        if (w > swdc_pkg::MAX_WINDOW_DEF) return swdc_pkg::MAX_WINDOW_DEF;
        return w;
    endfunction

    // slide the window by one value; returns 1 when the window is full
    function automatic bit track_sample(input logic [VW-1:0] v, output logic [OW-1:0] cnt);
        int unsigned   span;
        logic [VW-1:0] leaving;
        span = span_of(window_reg);
        if (window_vals.size() >= span) begin
            leaving = window_vals.pop_front();
            occurrences[leaving]--;
            if (occurrences[leaving] == 0) occurrences.delete(leaving);
        end
        window_vals.insert(window_vals.size(), v);
        if (occurrences.exists(v)) occurrences[v]++;
        else occurrences[v] = 1;
        cnt = OW'(occurrences.num());
        return window_vals.size() >= span;
    endfunction

    task automatic note_mismatch(input string what, input int exp_v, input int act_v);
        fail_count++;
        if (fail_count <= 10)
            $display("mismatch: %s expected %0d got %0d at %0t", what, exp_v, act_v, $realtime);
    endtask

    task automatic send_sample(input logic [VW-1:0] v, input logic typed,
                               input logic [OW-1:0] typed_count);
        logic [OW-1:0] predicted;
        s_valid        <= 1'b1;
        s_sample_value <= v;
        do @(posedge aclk); while (!s_ready);
        if (track_sample(v, predicted))
            expected_counts.insert(expected_counts.size(), typed ? typed_count : predicted);
    endtask

    task automatic idle_gap();
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        while (expected_counts.size() != 0) @(posedge aclk);
    endtask

    task automatic write_window(input logic [CW-1:0] w);
        s_valid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= w;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid  <= 1'b0;
        window_reg  = w;
        window_vals.delete();
        occurrences.delete();
    endtask

    // result checker
    always @(posedge aclk) begin
        logic [OW-1:0] want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_counts.size() == 0) begin
                note_mismatch("unexpected beat, count", 0, m_distinct_count);
            end else begin
                want = expected_counts.pop_front();
                if (m_distinct_count !== want)
                    note_mismatch("distinct_count", want, m_distinct_count);
            end
        end
    end

    // watchdog on cycles with no beat on any channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // result sink with random stalls and one long hold-off
    initial begin : sink
        int n;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 9);
                m_ready <= 1'b0;
                repeat (n) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    initial begin : main
        int            random_left;
        int            n_items;
        int            alpha_n;
        int            style;
        bit            first_phase;
        logic [CW-1:0] span;
        logic [VW-1:0] v;
        logic [VW-1:0] alphabet [64];
        logic [CW-1:0] extremes [5];

        extremes = '{7'd0, 7'd1, 7'd64, 7'd65, 7'd127};
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_WINDOW) begin
                write_window(directed_rows[i].value[CW-1:0]);
            end else begin
                send_sample(directed_rows[i].value, directed_rows[i].typed,
                            directed_rows[i].count);
                idle_gap();
            end
        end

        random_left = RANDOM_ITEMS;
        first_phase = 1'b1;
        while (random_left > 0) begin
            if ($urandom_range(0, 9) == 0) span = extremes[$urandom_range(0, 4)];
            else span = CW'($urandom_range(1, 12));
            write_window(span);
            // long receiver hold-off right at the start of the first random phase
            if (first_phase) begin
                hold_request = 1'b1;
                first_phase  = 1'b0;
            end
            style = $urandom_range(0, 3);
            case (style)
                0: alpha_n = 1;
                1: alpha_n = $urandom_range(1, 4);
                2: alpha_n = $urandom_range(5, 16);
                default: alpha_n = 64;
            endcase
            for (int k = 0; k < alpha_n; k++) alphabet[k] = $urandom;
            n_items = span_of(span) + $urandom_range(4, 40);
            if (n_items > random_left) n_items = random_left;
            repeat (n_items) begin
                if (random_left < CALM_TAIL) idle_on = 1'b0;
                if (style == 0 || $urandom_range(0, 7) == 0) v = $urandom;
                else v = alphabet[$urandom_range(0, alpha_n - 1)];
                send_sample(v, 1'b0, '0);
                idle_gap();
                random_left--;
            end
        end

        s_valid <= 1'b0;
        wait_drained();
        repeat (8) @(posedge aclk);
        if (fail_count == 0 && expected_counts.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
